FILE: rtl/scalar_kalman_smoother_top_defines.svh
// Assertion macros shared by the scalar Kalman smoother RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SCALAR_KALMAN_SMOOTHER_TOP_DEFINES_SVH
`define SCALAR_KALMAN_SMOOTHER_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SKF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must be followed by an outcome in the next cycle.
`define SKF_ASSERT_NEXT(label, cond, outcome, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (outcome)) \
    else $error(msg);

`endif

FILE: rtl/skf_pkg.sv
// Package for the scalar Kalman smoother: action and register codes,
// sequencer states and fixed widths. No dependencies.
`default_nettype none

package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] QN_RESET = 24'd655;
  localparam logic [CFG_W-1:0] RN_RESET = 24'd6554;

  typedef enum logic [1:0] {
    ACT_FILTER = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_PRESET = 2'd2
  } skf_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_NOISE = 2'd0,
    CFG_MEAS_NOISE    = 2'd1
  } skf_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_MUL_GAIN,
    ST_MUL_COV,
    ST_COV,
    ST_OUT
  } skf_state_e;

endpackage

`default_nettype wire

FILE: rtl/skf_if.sv
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on skf_pkg.
`default_nettype none

interface skf_in_if import skf_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, action, sample, input ready);
  modport sink   (input valid, action, sample, output ready);
endinterface

interface skf_out_if import skf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] smoothed;

  modport source (output valid, smoothed, input ready);
  modport sink   (input valid, smoothed, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/skf_divider.sv
// Radix-2 restoring divider for the gain: quo = floor(num * 2^F / den), num < den.
// One quotient bit per cycle. Depends on skf_pkg and the assertion macros.
`default_nettype none
`include "scalar_kalman_smoother_top_defines.svh"

module skf_divider import skf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DATA_W-1:0]    num_i,
  input  wire logic [DATA_W:0]      den_i,
  output logic                      done_o,
  output logic [FRAC_BITS-1:0]      quo_o
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DATA_W:0]   rem_q, rem_d;
  logic [DATA_W:0]   den_q, den_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;

  logic [DATA_W+1:0] trial;
  logic              fits;

  assign trial = {rem_q, 1'b0};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(FRAC_BITS);
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? (DATA_W + 1)'(trial - {1'b0, den_q}) : trial[DATA_W:0];
      quo_d = {quo_q[FRAC_BITS-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  `SKF_ASSERT_NEXT(a_start_busy, start_i, busy_q, "divider not busy after start")
  `SKF_ASSERT(a_done_idle, !(done_q && busy_q), "divider done while busy")
  `SKF_ASSERT(a_rem_below, !busy_q || (rem_q < den_q), "divider remainder not below divisor")

endmodule

`default_nettype wire

FILE: rtl/scalar_kalman_smoother_top.sv
// Scalar Kalman smoother, constant-value model, fixed point with FRAC_BITS fraction.
// Depends on skf_pkg, skf_if, skf_divider and the assertion macros.
//
//   channel  modport  payload                    handshake
//   in_i     sink     action[1:0], sample        valid/ready
//   out_o    source   smoothed[31:0] Q16.16      valid/ready
//   cfg_i    sink     index[1:0], data[23:0]     valid/ready, ready always high
//
// Primed filter item: ST_PRED, ST_DIV, ST_MUL_GAIN, ST_MUL_COV, ST_COV, then ST_OUT;
// the gain divider makes one bit per cycle; one shared multiplier does both products.
// Clear and preset stay in ST_IDLE and give no result; an unprimed sample goes to ST_OUT.
// in_i.ready is high only while the sequencer is idle; a waiting result does not block it.
// A result stalled by out_o.ready holds the sequencer until the output register frees.
// Reset is asynchronous, active low: estimate 0, covariance 1.0, unprimed.
`default_nettype none
`include "scalar_kalman_smoother_top_defines.svh"

module scalar_kalman_smoother_top import skf_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  skf_in_if.sink     in_i,
  skf_out_if.source  out_o,
  skf_cfg_if.sink    cfg_i
);

  localparam int ZW = (SAMPLE_BITS + FRAC_BITS > DATA_W + 1) ?
                      (SAMPLE_BITS + FRAC_BITS) : (DATA_W + 1);
  localparam int PW = DATA_W + FRAC_BITS + 2;
  localparam int QDEF = ((1 << FRAC_BITS) + 50) / 100;
  localparam int RDEF = ((1 << FRAC_BITS) + 5) / 10;

  localparam logic [DATA_W-1:0]     ONE_COV = DATA_W'(64'(1) << FRAC_BITS);
  localparam logic [FRAC_BITS:0]    ONE_K   = (FRAC_BITS + 1)'(64'(1) << FRAC_BITS);
  localparam logic signed [ZW-1:0]  Z_MAX   = ZW'(signed'(33'h0_7FFF_FFFF));
  localparam logic signed [ZW-1:0]  Z_MIN   = ZW'(signed'(33'h1_8000_0000));
  localparam logic signed [DATA_W+1:0] E_MAX = (DATA_W + 2)'(signed'(33'h0_7FFF_FFFF));
  localparam logic signed [DATA_W+1:0] E_MIN = (DATA_W + 2)'(signed'(33'h1_8000_0000));

  skf_state_e state_q, state_d;

  logic [CFG_W-1:0]         qn_q, rn_q;
  logic signed [DATA_W-1:0] est_q;
  logic [DATA_W-1:0]        cov_q;
  logic                     primed_q;
  logic [DATA_W:0]          absdiff_q;
  logic                     neg_q;
  logic [DATA_W-1:0]        pred_q;
  logic [PW-1:0]            prod_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_data_q;

  logic                     in_acc;
  logic                     out_free;
  logic                     div_start;
  logic                     div_done;
  logic [FRAC_BITS-1:0]     gain;

  logic signed [ZW-1:0]     z_wide;
  logic signed [DATA_W-1:0] z_sat;
  logic [DATA_W:0]          diff;
  logic [CFG_W-1:0]         q_eff, r_eff;
  logic [DATA_W:0]          pred_sum;
  logic [DATA_W-1:0]        pred;
  logic [DATA_W:0]          den;
  logic [DATA_W:0]          mul_a;
  logic [FRAC_BITS:0]       mul_b;
  logic [PW-1:0]            mul_p;
  logic [DATA_W:0]          delta_mag;
  logic [DATA_W+1:0]        delta_s;
  logic signed [DATA_W+1:0] est_sum;
  logic signed [DATA_W-1:0] est_new;

  // Sample scaling and saturation
  assign z_wide = ZW'(in_i.sample) <<< FRAC_BITS;
  always_comb begin
    if (z_wide > Z_MAX)      z_sat = Z_MAX[DATA_W-1:0];
    else if (z_wide < Z_MIN) z_sat = Z_MIN[DATA_W-1:0];
    else                     z_sat = z_wide[DATA_W-1:0];
  end
  assign diff = {z_sat[DATA_W-1], z_sat} - {est_q[DATA_W-1], est_q};

  // Prediction and gain divisor
  assign q_eff    = (qn_q != '0) ? qn_q : CFG_W'(QDEF);
  assign r_eff    = (rn_q != '0) ? rn_q : CFG_W'(RDEF);
  assign pred_sum = {1'b0, cov_q} + (DATA_W + 1)'(q_eff);
  assign pred     = pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];
  assign den      = {1'b0, pred} + (DATA_W + 1)'(r_eff);

  skf_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (pred),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (gain)
  );

  // Shared multiplier: |diff| * K, then (1 - K) * Ppred
  always_comb begin
    if (state_q == ST_MUL_COV) begin
      mul_a = {1'b0, pred_q};
      mul_b = ONE_K - {1'b0, gain};
    end else begin
      mul_a = absdiff_q;
      mul_b = {1'b0, gain};
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Estimate update, truncation toward zero via sign-magnitude
  assign delta_mag = prod_q[FRAC_BITS +: (DATA_W + 1)];
  assign delta_s   = neg_q ? ((DATA_W + 2)'(~{1'b0, delta_mag}) + (DATA_W + 2)'(1))
                           : {1'b0, delta_mag};
  assign est_sum   = signed'((DATA_W + 2)'(est_q) + delta_s);
  always_comb begin
    if (est_sum > E_MAX)      est_new = E_MAX[DATA_W-1:0];
    else if (est_sum < E_MIN) est_new = E_MIN[DATA_W-1:0];
    else                      est_new = est_sum[DATA_W-1:0];
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign in_acc   = in_i.valid && in_i.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.action == ACT_FILTER)) begin
          state_d = primed_q ? ST_PRED : ST_OUT;
        end
      end
      ST_PRED:     state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = ST_MUL_GAIN;
      end
      ST_MUL_GAIN: state_d = ST_MUL_COV;
      ST_MUL_COV:  state_d = ST_COV;
      ST_COV:      state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_PRED: div_start  = 1'b1;
      default: ;
    endcase
  end

  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.smoothed = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      qn_q        <= QN_RESET;
      rn_q        <= RN_RESET;
      est_q       <= '0;
      cov_q       <= ONE_COV;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_PROCESS_NOISE: qn_q <= cfg_i.data;
          CFG_MEAS_NOISE:    rn_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (in_acc) begin
        case (in_i.action)
          ACT_CLEAR: begin
            primed_q <= 1'b0;
            est_q    <= '0;
            cov_q    <= ONE_COV;
          end
          ACT_PRESET: begin
            primed_q <= 1'b1;
            est_q    <= z_sat;
            cov_q    <= ONE_COV;
          end
          ACT_FILTER: begin
            if (!primed_q) begin
              primed_q <= 1'b1;
              est_q    <= z_sat;
              cov_q    <= ONE_COV;
            end
          end
          default: ;
        endcase
      end
      if (state_q == ST_MUL_COV) est_q <= est_new;
      if (state_q == ST_COV)     cov_q <= prod_q[FRAC_BITS +: DATA_W];
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      neg_q     <= diff[DATA_W];
      absdiff_q <= diff[DATA_W] ? (DATA_W + 1)'(~diff + (DATA_W + 1)'(1)) : diff;
    end
    if (state_q == ST_PRED) pred_q <= pred;
    if (state_q == ST_MUL_GAIN || state_q == ST_MUL_COV) prod_q <= mul_p;
    if (state_q == ST_OUT && out_free) out_data_q <= est_q;
  end

  `SKF_ASSERT(a_delta_bound,
              (state_q != ST_MUL_COV) || (delta_mag <= absdiff_q),
              "update overshoots sample")
  `SKF_ASSERT(a_cov_bound,
              (state_q != ST_COV) || (prod_q[FRAC_BITS +: DATA_W] <= pred_q),
              "covariance grew in update")
  `SKF_ASSERT(a_out_src,
              !$rose(out_valid_q) || ($past(state_q) == ST_OUT),
              "result without output step")
  `SKF_ASSERT_NEXT(a_div_seq, (state_q == ST_DIV) && div_done, state_q == ST_MUL_GAIN,
                   "gain not used after divide")

endmodule

`default_nettype wire
